/* design/dnl_pkg.sv */
package dnl_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int CONSUMED_W = 16;
  localparam logic [CONSUMED_W-1:0] COUNT_LIMIT = (COUNT_WIDTH >= 16) ? 16'hFFFF
      : CONSUMED_W'((64'd1 << COUNT_WIDTH) - 64'd1);

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [7:0] FRAC_MAX = 8'hFF;

  localparam int OUT_TDATA_W = 216;
  localparam int OUT_TUSER_W = 2;

  typedef enum logic [2:0] {
    PH_INT,
    PH_FRAC,
    PH_ESIGN,
    PH_EXP,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [63:0]           integer_part;
    logic [63:0]           fraction_value;
    logic [7:0]            fraction_count;
    logic                  has_fraction;
    logic                  has_exponent;
    logic signed [63:0]    exponent_value;
    logic [CONSUMED_W-1:0] consumed;
  } result_t;

  function automatic logic [63:0] times_ten_plus(input logic [63:0] a, input logic [63:0] d);
    times_ten_plus = {a[60:0], 3'b000} + {a[62:0], 1'b0} + d;
  endfunction

endpackage

/* design/decimal_number_lexer.sv */
// Decimal number scanner, one character per cycle. Each request carries one
// ASCII character; it passes an input register, combinational scanning logic
// with the multiply-by-ten accumulators, and an output register, which holds
// the result of the request that ends a scan until it is drained; a new character
// is taken every cycle, stalling only when the output register is full and
// not drained. A scan ends at the first character that does not fit
// digits[.digits][e[+|-]digits] (that character is not counted) or at the
// request with tlast, which also clears the state; characters after the end
// are dropped until tlast. Accumulators wrap at 64 bits, counts saturate.
module decimal_number_lexer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,  // ch
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // integer_part, fraction_value, fraction_count, exponent_value, consumed
  output logic [dnl_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic [dnl_pkg::OUT_TUSER_W-1:0]   out_tuser  // has_fraction, has_exponent
);

  dnl_pkg::item_t   in_item;
  dnl_pkg::item_t   item;
  dnl_pkg::result_t res;
  dnl_pkg::result_t out_res;
  logic             item_valid;
  logic             take;
  logic             res_valid;
  logic             slot_free;

  assign in_item.ch   = in_tdata;
  assign in_item.last = in_tlast;

  dnl_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  dnl_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .slot_free  (slot_free),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  dnl_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (res_valid),
    .res        (res),
    .slot_free  (slot_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {out_res.consumed, out_res.exponent_value, out_res.fraction_count,
                      out_res.fraction_value, out_res.integer_part};
  assign out_tuser = {out_res.has_exponent, out_res.has_fraction};

endmodule

/* design/dnl_in_reg.sv */
module dnl_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  dnl_pkg::item_t  in_item,
  input  logic            take,
  output logic            item_valid,
  output dnl_pkg::item_t  item
);

  logic           valid_r;
  logic           valid_nxt;
  dnl_pkg::item_t item_r;

  assign in_tready = !valid_r || take;
  assign valid_nxt = (in_tvalid && in_tready) ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item = item_r;

endmodule

/* design/dnl_scan.sv */
module dnl_scan (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  dnl_pkg::item_t    item,
  input  logic              slot_free,
  output logic              take,
  output logic              res_valid,
  output dnl_pkg::result_t  res
);

  dnl_pkg::phase_t phase_r, phase_nxt;
  logic [63:0] int_acc_r, int_acc_nxt;
  logic [63:0] frac_acc_r, frac_acc_nxt;
  logic [7:0]  frac_digits_r, frac_digits_nxt;
  logic [63:0] exp_acc_r, exp_acc_nxt;
  logic        exp_neg_r, exp_neg_nxt;
  logic        seen_frac_r, seen_frac_nxt;
  logic        seen_exp_r, seen_exp_nxt;
  logic [dnl_pkg::CONSUMED_W-1:0] count_r, count_nxt;

  logic        dig;
  logic [63:0] d64;
  logic [63:0] sd64;
  logic        fits;
  logic        emit;
  dnl_pkg::phase_t phase_upd;
  logic [63:0] int_upd, frac_upd, exp_upd;
  logic [7:0]  frac_digits_upd;
  logic        exp_neg_upd, seen_frac_upd, seen_exp_upd;
  logic [dnl_pkg::CONSUMED_W-1:0] count_upd;

  assign dig  = (item.ch >= dnl_pkg::CH_ZERO) && (item.ch <= dnl_pkg::CH_NINE);
  assign d64  = dig ? {60'd0, 4'(item.ch - dnl_pkg::CH_ZERO)} : 64'd0;
  // exponent kept already signed: -(10a + d) = 10(-a) - d
  assign sd64 = exp_neg_r ? (64'd0 - d64) : d64;

  // phase transition of one consumed character
  always_comb begin
    phase_upd = phase_r;
    fits = 1'b0;
    unique case (phase_r)
      dnl_pkg::PH_INT: begin
        if (dig) begin
          fits = 1'b1;
        end else if (item.ch == dnl_pkg::CH_DOT) begin
          fits = 1'b1;
          phase_upd = dnl_pkg::PH_FRAC;
        end else if (item.ch == dnl_pkg::CH_E) begin
          fits = 1'b1;
          phase_upd = dnl_pkg::PH_ESIGN;
        end
      end
      dnl_pkg::PH_FRAC: begin
        if (dig) begin
          fits = 1'b1;
        end else if (item.ch == dnl_pkg::CH_E) begin
          fits = 1'b1;
          phase_upd = dnl_pkg::PH_ESIGN;
        end
      end
      dnl_pkg::PH_ESIGN: begin
        if (dig || item.ch == dnl_pkg::CH_MINUS || item.ch == dnl_pkg::CH_PLUS) begin
          fits = 1'b1;
          phase_upd = dnl_pkg::PH_EXP;
        end
      end
      dnl_pkg::PH_EXP: begin
        fits = dig;
      end
      default: begin
        fits = 1'b0;
      end
    endcase
  end

  assign emit = (phase_r != dnl_pkg::PH_DONE) && (!fits || item.last);
  assign take = item_valid && (!emit || slot_free);
  assign res_valid = take && emit;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (take) begin
      if (item.last) begin
        phase_nxt = dnl_pkg::PH_INT;
      end else if (emit) begin
        phase_nxt = dnl_pkg::PH_DONE;
      end else begin
        phase_nxt = phase_upd;
      end
    end
  end

  // accumulators and result
  always_comb begin
    int_upd         = int_acc_r;
    frac_upd        = frac_acc_r;
    frac_digits_upd = frac_digits_r;
    exp_upd         = exp_acc_r;
    exp_neg_upd     = exp_neg_r;
    seen_frac_upd   = seen_frac_r;
    seen_exp_upd    = seen_exp_r;
    count_upd       = count_r;
    if (fits) begin
      if (count_r < dnl_pkg::COUNT_LIMIT) begin
        count_upd = count_r + 1'b1;
      end
      case (phase_r)
        dnl_pkg::PH_INT: begin
          if (dig) begin
            int_upd = dnl_pkg::times_ten_plus(int_acc_r, d64);
          end else if (item.ch == dnl_pkg::CH_DOT) begin
            seen_frac_upd = 1'b1;
          end else begin
            seen_exp_upd = 1'b1;
          end
        end
        dnl_pkg::PH_FRAC: begin
          if (dig) begin
            frac_upd = dnl_pkg::times_ten_plus(frac_acc_r, d64);
            if (frac_digits_r != dnl_pkg::FRAC_MAX) begin
              frac_digits_upd = frac_digits_r + 1'b1;
            end
          end else begin
            seen_exp_upd = 1'b1;
          end
        end
        dnl_pkg::PH_ESIGN: begin
          if (item.ch == dnl_pkg::CH_MINUS) begin
            exp_neg_upd = 1'b1;
          end else if (dig) begin
            exp_upd = dnl_pkg::times_ten_plus(exp_acc_r, sd64);
          end
        end
        default: begin
          exp_upd = dnl_pkg::times_ten_plus(exp_acc_r, sd64);
        end
      endcase
    end

    res.integer_part   = int_upd;
    res.fraction_value = frac_upd;
    res.fraction_count = frac_digits_upd;
    res.has_fraction   = seen_frac_upd;
    res.has_exponent   = seen_exp_upd;
    res.exponent_value = exp_upd;
    res.consumed       = count_upd;

    int_acc_nxt     = int_acc_r;
    frac_acc_nxt    = frac_acc_r;
    frac_digits_nxt = frac_digits_r;
    exp_acc_nxt     = exp_acc_r;
    exp_neg_nxt     = exp_neg_r;
    seen_frac_nxt   = seen_frac_r;
    seen_exp_nxt    = seen_exp_r;
    count_nxt       = count_r;
    if (take) begin
      if (item.last) begin
        int_acc_nxt     = '0;
        frac_acc_nxt    = '0;
        frac_digits_nxt = '0;
        exp_acc_nxt     = '0;
        exp_neg_nxt     = 1'b0;
        seen_frac_nxt   = 1'b0;
        seen_exp_nxt    = 1'b0;
        count_nxt       = '0;
      end else if (phase_r != dnl_pkg::PH_DONE) begin
        int_acc_nxt     = int_upd;
        frac_acc_nxt    = frac_upd;
        frac_digits_nxt = frac_digits_upd;
        exp_acc_nxt     = exp_upd;
        exp_neg_nxt     = exp_neg_upd;
        seen_frac_nxt   = seen_frac_upd;
        seen_exp_nxt    = seen_exp_upd;
        count_nxt       = count_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= dnl_pkg::PH_INT;
      int_acc_r     <= '0;
      frac_acc_r    <= '0;
      frac_digits_r <= '0;
      exp_acc_r     <= '0;
      exp_neg_r     <= 1'b0;
      seen_frac_r   <= 1'b0;
      seen_exp_r    <= 1'b0;
      count_r       <= '0;
    end else begin
      phase_r       <= phase_nxt;
      int_acc_r     <= int_acc_nxt;
      frac_acc_r    <= frac_acc_nxt;
      frac_digits_r <= frac_digits_nxt;
      exp_acc_r     <= exp_acc_nxt;
      exp_neg_r     <= exp_neg_nxt;
      seen_frac_r   <= seen_frac_nxt;
      seen_exp_r    <= seen_exp_nxt;
      count_r       <= count_nxt;
    end
  end

  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == dnl_pkg::PH_DONE) |-> !res_valid)
    else $error("result raised after end of scan");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (take && item.last) |=> (phase_r == dnl_pkg::PH_INT) && (count_r == '0))
    else $error("state not cleared after last request");

  a_frac_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == dnl_pkg::PH_FRAC) |-> seen_frac_r)
    else $error("fraction phase without dot flag");

  a_int_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == dnl_pkg::PH_INT) |-> (!seen_frac_r && !seen_exp_r && !exp_neg_r))
    else $error("integer phase with stale flags");

endmodule

/* design/dnl_out_reg.sv */
module dnl_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  dnl_pkg::result_t  res,
  output logic              slot_free,
  output logic              out_tvalid,
  input  logic              out_tready,
  output dnl_pkg::result_t  out_res
);

  logic             valid_r;
  logic             valid_nxt;
  dnl_pkg::result_t res_r;

  assign slot_free = !valid_r || out_tready;
  assign valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_res = res_r;

endmodule

/* sim/decimal_number_lexer_tb.sv */
`timescale 1ns / 1ps

module decimal_number_lexer_tb;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [7:0]                      in_tdata;
  logic                            in_tlast;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [dnl_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [dnl_pkg::OUT_TUSER_W-1:0] out_tuser;

  decimal_number_lexer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // scanner state mirror
  dnl_pkg::phase_t                ph;
  logic [63:0]                    acc_int;
  logic [63:0]                    acc_frac;
  logic [7:0]                     nfrac;
  logic [63:0]                    acc_exp;
  logic                           exp_neg;
  logic                           dot_seen;
  logic                           e_seen;
  logic [dnl_pkg::CONSUMED_W-1:0] nchars;

  dnl_pkg::result_t scan_q[$];
  int      errors = 0;
  int      live_items = 0;
  bit      gapless = 1'b0;
  bit      hold_req = 1'b0;

  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(10, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic void clear_scan();
    ph = dnl_pkg::PH_INT;
    acc_int = '0;
    acc_frac = '0;
    nfrac = '0;
    acc_exp = '0;
    exp_neg = 1'b0;
    dot_seen = 1'b0;
    e_seen = 1'b0;
    nchars = '0;
  endfunction

  function automatic void scan_char(input logic [7:0] c, input logic l);
    logic             dig;
    logic [63:0]      d;
    logic             fits;
    dnl_pkg::result_t r;
    if (ph == dnl_pkg::PH_DONE) begin
      if (l) clear_scan();
      return;
    end
    dig = (c >= dnl_pkg::CH_ZERO) && (c <= dnl_pkg::CH_NINE);
    d = dig ? 64'(c - dnl_pkg::CH_ZERO) : 64'd0;
    fits = 1'b1;
    case (ph)
      dnl_pkg::PH_INT: begin
        if (dig) acc_int = acc_int * 64'd10 + d;
        else if (c == dnl_pkg::CH_DOT) begin
          dot_seen = 1'b1;
          ph = dnl_pkg::PH_FRAC;
        end else if (c == dnl_pkg::CH_E) begin
          e_seen = 1'b1;
          ph = dnl_pkg::PH_ESIGN;
        end else fits = 1'b0;
      end
      dnl_pkg::PH_FRAC: begin
        if (dig) begin
          acc_frac = acc_frac * 64'd10 + d;
          if (nfrac != dnl_pkg::FRAC_MAX) nfrac = nfrac + 8'd1;
        end else if (c == dnl_pkg::CH_E) begin
          e_seen = 1'b1;
          ph = dnl_pkg::PH_ESIGN;
        end else fits = 1'b0;
      end
      dnl_pkg::PH_ESIGN: begin
        if (c == dnl_pkg::CH_MINUS) begin
          exp_neg = 1'b1;
          ph = dnl_pkg::PH_EXP;
        end else if (c == dnl_pkg::CH_PLUS) begin
          ph = dnl_pkg::PH_EXP;
        end else if (dig) begin
          acc_exp = acc_exp * 64'd10 + d;
          ph = dnl_pkg::PH_EXP;
        end else fits = 1'b0;
      end
      dnl_pkg::PH_EXP: begin
        if (dig) acc_exp = acc_exp * 64'd10 + d;
        else fits = 1'b0;
      end
      default: fits = 1'b0;
    endcase
    if (fits && nchars < dnl_pkg::COUNT_LIMIT) nchars = nchars + 1'b1;
    if (fits && !l) return;
    r.integer_part = acc_int;
    r.fraction_value = acc_frac;
    r.fraction_count = nfrac;
    r.has_fraction = dot_seen;
    r.has_exponent = e_seen;
    r.exponent_value = exp_neg ? -acc_exp : acc_exp;
    r.consumed = nchars;
    scan_q.push_back(r);
    if (l) clear_scan();
    else ph = dnl_pkg::PH_DONE;
  endfunction

  task automatic send_char(input logic [7:0] c, input logic l);
    int gap;
    gap = (gapless || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tlast <= l;
    do @(posedge clk); while (!in_tready);
    if (ph != dnl_pkg::PH_DONE) live_items++;
    scan_char(c, l);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], i == s.len() - 1);
    end
  endtask

  task automatic report(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endtask

  task automatic check_result();
    dnl_pkg::result_t want;
    dnl_pkg::result_t got;
    got.integer_part = out_tdata[63:0];
    got.fraction_value = out_tdata[127:64];
    got.fraction_count = out_tdata[135:128];
    got.exponent_value = out_tdata[199:136];
    got.consumed = out_tdata[215:200];
    got.has_fraction = out_tuser[0];
    got.has_exponent = out_tuser[1];
    if (scan_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result expected none got %h", $time, out_tdata);
      return;
    end
    want = scan_q.pop_front();
    report("integer_part", want.integer_part, got.integer_part);
    report("fraction_value", want.fraction_value, got.fraction_value);
    report("fraction_count", 64'(want.fraction_count), 64'(got.fraction_count));
    report("has_fraction", 64'(want.has_fraction), 64'(got.has_fraction));
    report("has_exponent", 64'(want.has_exponent), 64'(got.has_exponent));
    report("exponent_value", want.exponent_value, got.exponent_value);
    report("consumed", 64'(want.consumed), 64'(got.consumed));
  endtask

  // result side: checking and back-pressure
  initial begin
    int  hold_left;
    int  stall_left;
    int  mode_left;
    bit  calm;
    hold_left = 0;
    stall_left = 0;
    mode_left = 0;
    calm = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) check_result();
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      if (mode_left == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(20, 120);
      end else mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        stall_left = idle_len() - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic test_full_number();
    send_text("12.5e-3;");
    send_text("907e+15");
    send_text("0.0");
  endtask

  task automatic test_no_digits();
    send_text(".");
    send_text("e");
    send_text("x");
    send_text("..");
  endtask

  task automatic test_exponent_sign_only();
    send_text("e-");
    send_text("e+z");
  endtask

  task automatic test_after_end();
    send_char("5", 1'b0);
    send_char("a", 1'b0);
    send_char("9", 1'b0);
    send_char(8'hFF, 1'b1);
  endtask

  task automatic test_char_extremes();
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    send_char(dnl_pkg::CH_NINE, 1'b1);
  endtask

  // long fraction so that the digit count saturates and the fraction wraps
  task automatic test_count_saturation();
    gapless = 1'b1;
    send_char(dnl_pkg::CH_DOT, 1'b0);
    for (int i = 0; i < 260; i++) begin
      send_char(8'($urandom_range(dnl_pkg::CH_ZERO, dnl_pkg::CH_NINE)), i == 259);
    end
    gapless = 1'b0;
  endtask

  task automatic test_output_backpressure();
    gapless = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_char(8'($urandom_range(dnl_pkg::CH_ZERO, dnl_pkg::CH_NINE)), 1'b1);
    end
    gapless = 1'b0;
  endtask

  function automatic void add_digits(ref logic [7:0] q[$]);
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 25) : $urandom_range(0, 5);
    repeat (n) q.push_back(8'($urandom_range(dnl_pkg::CH_ZERO, dnl_pkg::CH_NINE)));
  endfunction

  task automatic test_random_text();
    logic [7:0] q[$];
    int         stop_at;
    int         kind;
    stop_at = live_items + 400;
    while (live_items < stop_at) begin
      q.delete();
      kind = $urandom_range(0, 99);
      gapless = ($urandom_range(0, 7) == 0);
      if (kind < 88) begin
        add_digits(q);
        if ($urandom_range(0, 1)) begin
          q.push_back(dnl_pkg::CH_DOT);
          add_digits(q);
        end
        if ($urandom_range(0, 1)) begin
          q.push_back(dnl_pkg::CH_E);
          case ($urandom_range(0, 2))
            0: q.push_back(dnl_pkg::CH_MINUS);
            1: q.push_back(dnl_pkg::CH_PLUS);
            default: ;
          endcase
          add_digits(q);
        end
        if (kind >= 76 && q.size() > 0) begin
          q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 1)) begin
          repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(0, 255)));
        end
        if (q.size() == 0) q.push_back(8'($urandom_range(0, 255)));
        for (int i = 0; i < q.size(); i++) begin
          send_char(q[i], i == q.size() - 1);
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
        send_char(8'($urandom_range(0, 255)), 1'b1);
      end
    end
    gapless = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    clear_scan();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_full_number();
    test_no_digits();
    test_exponent_sign_only();
    test_after_end();
    test_char_extremes();
    test_output_backpressure();
    test_count_saturation();
    test_random_text();
    in_tvalid <= 1'b0;
    while (scan_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && scan_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* decimal_number_lexer.f */
design/dnl_pkg.sv
design/dnl_in_reg.sv
design/dnl_scan.sv
design/dnl_out_reg.sv
design/decimal_number_lexer.sv
sim/decimal_number_lexer_tb.sv
